FILE: src/dpfc_pkg.sv
// Shared types and constants for the duplicate-filtering packet FIFO.
package dpfc_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int LIMIT_W   = 5;
    localparam int CNT_W     = 5;
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 5'd16;
    localparam logic [CNT_W-1:0]   COUNT_MAX  = 5'd31;
    localparam logic [PADDR_W-1:0] ADDR_LIMIT = 2'd0;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_FWD   = 2'd1,
        KIND_COUNT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [15:0] source;
        logic [15:0] destination;
        logic [31:0] timestamp;
    } pkt_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] source;
        logic [15:0] destination;
        logic [31:0] timestamp;
        logic [31:0] start_time;
        logic [31:0] end_time;
    } req_item_t;

    typedef struct packed {
        logic             accepted;
        logic             packet_valid;
        logic [15:0]      out_source;
        logic [15:0]      out_destination;
        logic [31:0]      out_timestamp;
        logic [CNT_W-1:0] match_count;
    } rsp_item_t;

    typedef struct packed {
        logic rotate;
        logic load;
    } cell_ctrl_t;

endpackage

FILE: src/dpfc_cell.sv
// One storage cell of the packet ring: holds a packet, loads or takes its neighbor's.
module dpfc_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  logic                clk,
    input  dpfc_pkg::cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]    load_index,
    input  dpfc_pkg::pkt_t      load_pkt,
    input  dpfc_pkg::pkt_t      neighbor,
    output dpfc_pkg::pkt_t      pkt
);
    import dpfc_pkg::*;

    pkt_t data_reg;
    pkt_t data_next;
    logic load_here;

    assign load_here = ctrl.load && (load_index == IDX_W'(IDX));

    // A load wins over rotation so an evicting add can shift and append at once.
    always_comb
    begin
        data_next = data_reg;
        if (load_here)
        begin
            data_next = load_pkt;
        end
        else if (ctrl.rotate)
        begin
            data_next = neighbor;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign pkt = data_reg;

endmodule

FILE: src/dpfc_ctrl.sv
// Sequencer: scans the ring at its head cell, applies add/forward/count, holds the response.
module dpfc_ctrl #(
    parameter int DEPTH = dpfc_pkg::DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int OCC_W = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  dpfc_pkg::req_item_t           req_item,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output dpfc_pkg::rsp_item_t           rsp_item,
    input  logic [dpfc_pkg::LIMIT_W-1:0]  memory_limit,
    input  dpfc_pkg::pkt_t                head_pkt,
    output dpfc_pkg::cell_ctrl_t          cell_ctrl,
    output logic [IDX_W-1:0]              load_index,
    output dpfc_pkg::pkt_t                load_pkt
);
    import dpfc_pkg::*;

    localparam int LIM_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             dup_reg, dup_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_item_t        rsp_reg, rsp_next;
    req_item_t        req_reg;

    logic [LIM_W-1:0] lim_raw;
    logic [LIM_W-1:0] lim_eff;
    logic             evict;
    logic             step_live;
    logic             dup_hit;
    logic             cnt_hit;
    logic             fin_go;
    logic             last_step;
    logic [OCC_W-1:0] occ_m1;

    assign lim_raw = LIM_W'(memory_limit);

    // A limit of zero acts as one, a limit above the ring depth as the depth.
    always_comb
    begin
        if (lim_raw == '0)
        begin
            lim_eff = LIM_W'(1);
        end
        else if (lim_raw > LIM_W'(DEPTH))
        begin
            lim_eff = LIM_W'(DEPTH);
        end
        else
        begin
            lim_eff = lim_raw;
        end
    end

    assign evict     = LIM_W'(occ_reg) >= lim_eff;
    assign occ_m1    = occ_reg - OCC_W'(1);
    assign step_live = OCC_W'(step_reg) < occ_reg;
    assign last_step = step_reg == IDX_W'(DEPTH - 1);
    assign fin_go    = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready);

    assign load_pkt.source      = req_reg.source;
    assign load_pkt.destination = req_reg.destination;
    assign load_pkt.timestamp   = req_reg.timestamp;

    assign dup_hit = step_live && (head_pkt == load_pkt);
    assign cnt_hit = step_live
                     && (head_pkt.destination == req_reg.destination)
                     && (head_pkt.timestamp >= req_reg.start_time)
                     && (head_pkt.timestamp <= req_reg.end_time)
                     && (cnt_reg != COUNT_MAX);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_item.kind == KIND_ADD || req_item.kind == KIND_COUNT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs toward the request channel and the cell row.
    always_comb
    begin
        req_ready  = 1'b0;
        cell_ctrl  = '0;
        load_index = evict ? IDX_W'(occ_m1) : IDX_W'(occ_reg);
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_SCAN:
            begin
                // Each scan cycle brings the next oldest packet to the head cell.
                cell_ctrl.rotate = 1'b1;
            end
            ST_FINISH:
            begin
                if (fin_go)
                begin
                    case (req_reg.kind)
                        KIND_ADD:
                        begin
                            if (!dup_reg)
                            begin
                                cell_ctrl.load   = 1'b1;
                                cell_ctrl.rotate = evict;
                            end
                        end
                        KIND_FWD:
                        begin
                            cell_ctrl.rotate = occ_reg != '0;
                        end
                        default:
                        begin
                            cell_ctrl = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        step_next      = step_reg;
        occ_next       = occ_reg;
        dup_next       = dup_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                dup_next  = 1'b0;
                cnt_next  = '0;
            end
            ST_SCAN:
            begin
                step_next = step_reg + IDX_W'(1);
                dup_next  = dup_reg | dup_hit;
                if (cnt_hit)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (fin_go)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    case (req_reg.kind)
                        KIND_ADD:
                        begin
                            if (!dup_reg)
                            begin
                                rsp_next.accepted = 1'b1;
                                if (!evict)
                                begin
                                    occ_next = occ_reg + OCC_W'(1);
                                end
                            end
                        end
                        KIND_FWD:
                        begin
                            if (occ_reg != '0)
                            begin
                                rsp_next.packet_valid    = 1'b1;
                                rsp_next.out_source      = head_pkt.source;
                                rsp_next.out_destination = head_pkt.destination;
                                rsp_next.out_timestamp   = head_pkt.timestamp;
                                occ_next                 = occ_m1;
                            end
                        end
                        KIND_COUNT:
                        begin
                            rsp_next.match_count = cnt_reg;
                        end
                        default:
                        begin
                            rsp_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            occ_reg       <= '0;
            dup_reg       <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            occ_reg       <= occ_next;
            dup_reg       <= dup_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (req_valid && req_ready)
        begin
            req_reg <= req_item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

endmodule

FILE: src/dedup_packet_fifo_with_count_core.sv
// Top level: packet ring of cells, sequencer and the limit register port.
// Add and count rotate the whole ring before they respond: the ring rotates one
// packet per cycle past the comparators at the head cell. Forward and unused kinds
// skip the scan and go straight to the finish state. A new request is taken only after
// the previous response is registered; a response not yet taken holds the finish state.
// Reset clears the queue (empty, head at cell 0) and sets memory_limit to 16.
module dedup_packet_fifo_with_count_core #(
    parameter int DEPTH = dpfc_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  dpfc_pkg::req_item_t           req_item,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output dpfc_pkg::rsp_item_t           rsp_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dpfc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dpfc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dpfc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import dpfc_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [LIMIT_W-1:0] limit_reg;
    cell_ctrl_t         cell_ctrl;
    logic [IDX_W-1:0]   load_index;
    pkt_t               load_pkt;
    pkt_t               cell_pkt [DEPTH];

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LIMIT) ? PDATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RST;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_LIMIT)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    dpfc_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .OCC_W (OCC_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_item     (req_item),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp_item     (rsp_item),
        .memory_limit (limit_reg),
        .head_pkt     (cell_pkt[0]),
        .cell_ctrl    (cell_ctrl),
        .load_index   (load_index),
        .load_pkt     (load_pkt)
    );

    // Outside a scan, cell 0 holds the oldest packet; each cell takes from the next one up, the last from cell 0.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % DEPTH;

        dpfc_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .load_index (load_index),
            .load_pkt   (load_pkt),
            .neighbor   (cell_pkt[NXT]),
            .pkt        (cell_pkt[i])
        );
    end

endmodule

FILE: test/dedup_packet_fifo_with_count_core_tb.sv
// Self-checking testbench for the duplicate-filtering packet FIFO with windowed count.
`timescale 1ns / 100ps

module dedup_packet_fifo_with_count_core_tb;
    import dpfc_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 140;
    localparam int RECENT_MAX  = 24;
    localparam int SLOT_W      = (DEPTH_DEF > 1) ? $clog2(DEPTH_DEF) : 1;

    class packet_queue_model;
        pkt_t             store [DEPTH_DEF];
        int unsigned      head;
        int unsigned      occ;
        logic [LIMIT_W-1:0] limit;
        rsp_item_t        pending_rsp [$];
        int unsigned      errors;
        int unsigned      stored;
        int unsigned      dups;
        int unsigned      evictions;
        int unsigned      popped;
        int unsigned      empty_pops;
        int unsigned      counts;
        int unsigned      best_count;
        int unsigned      unused_ops;

        function new();
            head = 0;
            occ = 0;
            limit = LIMIT_RST;
            errors = 0;
            stored = 0;
            dups = 0;
            evictions = 0;
            popped = 0;
            empty_pops = 0;
            counts = 0;
            best_count = 0;
            unused_ops = 0;
        endfunction

        function void set_limit(input logic [LIMIT_W-1:0] value);
            limit = value;
        endfunction

        function logic [SLOT_W-1:0] ring_slot(input int unsigned offset);
            return SLOT_W'((head + offset) % DEPTH_DEF);
        endfunction

        // A limit of zero behaves as one, and anything above the depth as the depth.
        function int unsigned active_limit();
            int unsigned lim;
            lim = 32'(limit);
            if (lim == 0)
                lim = 1;
            if (lim > DEPTH_DEF)
                lim = DEPTH_DEF;
            return lim;
        endfunction

        function void take_request(input req_item_t r);
            rsp_item_t   want;
            pkt_t        p;
            bit          dup;
            int unsigned n;
            want = '0;
            case (r.kind)
                KIND_ADD: begin
                    p.source = r.source;
                    p.destination = r.destination;
                    p.timestamp = r.timestamp;
                    dup = 1'b0;
                    for (int i = 0; i < occ; i++)
                        if (store[ring_slot(i)] == p)
                            dup = 1'b1;
                    if (dup) begin
                        dups++;
                    end
                    else begin
                        // Only one packet is evicted, even if the limit was lowered further.
                        if (occ >= active_limit()) begin
                            head = 32'(ring_slot(1));
                            occ--;
                            evictions++;
                        end
                        store[ring_slot(occ)] = p;
                        occ++;
                        want.accepted = 1'b1;
                        stored++;
                    end
                end
                KIND_FWD: begin
                    if (occ != 0) begin
                        p = store[ring_slot(0)];
                        head = 32'(ring_slot(1));
                        occ--;
                        want.packet_valid = 1'b1;
                        want.out_source = p.source;
                        want.out_destination = p.destination;
                        want.out_timestamp = p.timestamp;
                        popped++;
                    end
                    else begin
                        empty_pops++;
                    end
                end
                KIND_COUNT: begin
                    n = 0;
                    for (int i = 0; i < occ; i++) begin
                        p = store[ring_slot(i)];
                        if (p.destination == r.destination && p.timestamp >= r.start_time
                            && p.timestamp <= r.end_time && n < COUNT_MAX)
                            n++;
                    end
                    want.match_count = n[CNT_W-1:0];
                    counts++;
                    if (n > best_count)
                        best_count = n;
                end
                default: unused_ops++;
            endcase
            pending_rsp = {pending_rsp, want};
        endfunction

        function void field_check(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (got !== want) begin
                $display("%0t ns %s mismatch: expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(input rsp_item_t got);
            rsp_item_t want;
            if (pending_rsp.size() == 0) begin
                $display("%0t ns unexpected response: expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            field_check("accepted", 32'(want.accepted), 32'(got.accepted));
            field_check("packet_valid", 32'(want.packet_valid), 32'(got.packet_valid));
            field_check("out_source", 32'(want.out_source), 32'(got.out_source));
            field_check("out_destination", 32'(want.out_destination),
                        32'(got.out_destination));
            field_check("out_timestamp", want.out_timestamp, got.out_timestamp);
            field_check("match_count", 32'(want.match_count), 32'(got.match_count));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    req_item_t           req_item = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_item_t           rsp_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    packet_queue_model   model;
    pkt_t                recent_pkts [$];
    bit                  no_idle = 1'b0;
    int unsigned         hold_request = 0;
    int unsigned         sent_total = 0;
    int                  cycle_count = 0;

    logic [LIMIT_W-1:0]  phase_limits [10] = '{5'd31, 5'd16, 5'd3, 5'd1, 5'd16,
                                               5'd8, 5'd0, 5'd12, 5'd5, 5'd16};

    dedup_packet_fifo_with_count_core #(
        .DEPTH(DEPTH_DEF)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_item(req_item),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_item(rsp_item),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses outstanding.",
                     cycle_count, model.pending_rsp.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return 32'($urandom_range(0, 15));
            5:       return 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
            default: return 32'($urandom);
        endcase
    endfunction

    // Fields that the operation ignores still carry random data.
    function automatic req_item_t noisy_request(input logic [1:0] kind);
        req_item_t r;
        r.kind = kind;
        r.source = 16'($urandom);
        r.destination = 16'($urandom);
        r.timestamp = $urandom;
        r.start_time = $urandom;
        r.end_time = $urandom;
        return r;
    endfunction

    function automatic req_item_t add_request(input logic [15:0] src, input logic [15:0] dst,
                                              input logic [31:0] ts);
        req_item_t r;
        r = noisy_request(KIND_ADD);
        r.source = src;
        r.destination = dst;
        r.timestamp = ts;
        return r;
    endfunction

    function automatic req_item_t count_request(input logic [15:0] dst, input logic [31:0] lo,
                                                input logic [31:0] hi);
        req_item_t r;
        r = noisy_request(KIND_COUNT);
        r.destination = dst;
        r.start_time = lo;
        r.end_time = hi;
        return r;
    endfunction

    // A quarter of the adds repeat a recent packet, which may or may not still be stored.
    function automatic req_item_t random_add();
        pkt_t p;
        if (recent_pkts.size() != 0 && $urandom_range(0, 3) == 0) begin
            p = recent_pkts[$urandom_range(0, recent_pkts.size() - 1)];
        end
        else begin
            p.source = pick_id();
            p.destination = pick_id();
            p.timestamp = pick_stamp();
        end
        recent_pkts = {recent_pkts, p};
        if (recent_pkts.size() > RECENT_MAX)
            void'(recent_pkts.pop_front());
        return add_request(p.source, p.destination, p.timestamp);
    endfunction

    function automatic req_item_t random_count();
        pkt_t        p;
        logic [31:0] lo;
        logic [31:0] hi;
        if (recent_pkts.size() != 0 && $urandom_range(0, 4) != 0) begin
            p = recent_pkts[$urandom_range(0, recent_pkts.size() - 1)];
        end
        else begin
            p.destination = pick_id();
            p.timestamp = pick_stamp();
        end
        case ($urandom_range(0, 4))
            0: begin
                lo = 32'h0000_0000;
                hi = 32'hFFFF_FFFF;
            end
            1: begin
                lo = p.timestamp;
                hi = p.timestamp;
            end
            2: begin
                lo = (p.timestamp > 32'd8) ? p.timestamp - $urandom_range(0, 8) : 32'd0;
                hi = (p.timestamp < 32'hFFFF_FFF7) ? p.timestamp + $urandom_range(0, 8)
                                                   : 32'hFFFF_FFFF;
            end
            3: begin
                lo = pick_stamp();
                hi = pick_stamp();
            end
            default: begin
                lo = $urandom;
                hi = $urandom;
            end
        endcase
        return count_request(p.destination, lo, hi);
    endfunction

    function automatic req_item_t random_request(input bit add_heavy);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < (add_heavy ? 60 : 35))
            return random_add();
        else if (roll < 78)
            return noisy_request(KIND_FWD);
        else if (roll < 96)
            return random_count();
        else
            return noisy_request(KIND_UNUSED);
    endfunction

    task automatic send_request(input req_item_t item);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item <= item;
        do @(posedge clk); while (!req_ready);
        model.take_request(item);
        sent_total++;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        do @(posedge clk); while (model.pending_rsp.size() != 0);
    endtask

    // Optionally writes memory_limit, then reads it back and compares.
    task automatic limit_access(input bit do_write, input logic [LIMIT_W-1:0] value);
        logic [PDATA_W-1:0] data;
        data = $urandom;
        data[LIMIT_W-1:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_LIMIT;
        if (do_write) begin
            pwrite <= 1'b1;
            pwdata <= data;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            penable <= 1'b0;
            model.set_limit(value);
        end
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[LIMIT_W-1:0] !== value) begin
            $display("%0t ns memory_limit read back: expected %0d, got %0d",
                     $time, value, prdata[LIMIT_W-1:0]);
            model.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_request != 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            else begin
                stall = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (stall != 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            model.check_response(rsp_item);
        end
    end

    initial
    begin
        model = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        limit_access(1'b0, LIMIT_RST);

        // Empty queue, field extremes, duplicates and window edges.
        send_request(noisy_request(KIND_FWD));
        send_request(count_request(16'hFFFF, 32'h0, 32'hFFFF_FFFF));
        send_request(add_request(16'h0, 16'h0, 32'h0));
        send_request(add_request(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(add_request(16'h0, 16'h0, 32'h0));
        send_request(add_request(16'd1, 16'hFFFF, 32'd5));
        send_request(add_request(16'd2, 16'hFFFF, 32'd10));
        send_request(count_request(16'hFFFF, 32'h0, 32'hFFFF_FFFF));
        send_request(count_request(16'hFFFF, 32'd5, 32'd10));
        send_request(count_request(16'hFFFF, 32'd10, 32'd5));
        send_request(count_request(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request('1);
        send_request(noisy_request(KIND_FWD));
        send_request(noisy_request(KIND_FWD));
        wait_idle();

        // Lowering the limit below occupancy: an add drops only one packet.
        limit_access(1'b1, 5'd1);
        send_request(add_request(16'd3, 16'd3, 32'd3));
        send_request(noisy_request(KIND_FWD));
        send_request(noisy_request(KIND_FWD));
        send_request(noisy_request(KIND_FWD));
        wait_idle();

        // A limit of zero holds a single packet.
        limit_access(1'b1, 5'd0);
        send_request(add_request(16'd4, 16'd4, 32'd4));
        send_request(add_request(16'd5, 16'd5, 32'd5));
        send_request(noisy_request(KIND_FWD));
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            limit_access(1'b1, phase_limits[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == 30)
                    no_idle = 1'b1;
                if (k == 60)
                    no_idle = 1'b0;
                if ((ph == 2 || ph == 7) && k == 80)
                    hold_request = 300;
                if (ph == 5 && k == 100)
                    wait_idle();
                send_request(random_request(ph % 2 == 0));
            end
            wait_idle();
        end

        repeat (DEPTH_DEF + 4) @(posedge clk);
        if (model.pending_rsp.size() != 0) begin
            $display("%0t ns %0d responses never arrived", $time, model.pending_rsp.size());
            model.errors++;
        end
        $display("Sent %0d requests over 13 limit settings: %0d packets stored, %0d duplicates",
                 sent_total, model.stored, model.dups);
        $display("rejected, %0d evictions, %0d forwarded, %0d empty forwards, %0d counts (max %0d).",
                 model.evictions, model.popped, model.empty_pops, model.counts, model.best_count);
        if (model.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: dedup_packet_fifo_with_count_core.f
src/dpfc_pkg.sv
src/dpfc_cell.sv
src/dpfc_ctrl.sv
src/dedup_packet_fifo_with_count_core.sv
test/dedup_packet_fifo_with_count_core_tb.sv
